// ===== sv/cdg_pkg.sv =====
// Shared constants, register codes and the result record of the central difference gradient unit.
package cdg_pkg;

  localparam int CNT_W          = 10;    // column and row counters
  localparam int CNT_LIMIT      = 1024;  // counters hold 0..1023
  localparam int CFG_W          = 11;    // slice_width / slice_height
  localparam int CFG_IDX_W      = 1;     // register index
  localparam int GRAD_W         = 9;     // Q8.1 gradient fields
  localparam int GRAD_SAT       = 255;   // largest raw gradient magnitude
  localparam int MIN_SIZE       = 3;     // smallest usable width or height
  localparam int SIZE_RESET     = 256;   // reset value of both size registers
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int VOXEL_BITS_DEF = 8;
  localparam int Q_DEPTH        = 3;     // result queue entries

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLICE_WIDTH  = 1'b0,
    REG_SLICE_HEIGHT = 1'b1
  } cdg_reg_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic        [CNT_W-1:0]  col_index;
    logic        [CNT_W-1:0]  row_index;
    logic                     last_in_slice;
  } cdg_result_t;

endpackage

// ===== sv/central_difference_gradient_xy_unit.sv =====
// Top level of the central difference gradient unit (x and y, Q8.1, raster voxel stream).
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_stall  | voxel_value
//  out     | out_valid / out_stall| grad_x, grad_y, col_index, row_index, last_in_slice
//  cfg     | cfg_write            | cfg_index, cfg_data (slice_width, slice_height)
//
// One voxel per cycle while in_stall is low; each item passes through the line store read
// stage s1, and its result is offered on the output from the result queue in the cycle
// after s1.
// Rate is set by the line stores: one read and one write of each per cycle while voxels flow.
// Reset clears the counters, the pipeline valid and the result queue; line stores
// hold whatever they held, and only their reads at columns written in earlier rows feed a result.
// in_stall comes from registered state only: it rises once the three entry result
// queue plus the item in flight could fill it, so out_stall never reaches the input
// combinationally.
module central_difference_gradient_xy_unit
  import cdg_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int VOXEL_BITS = VOXEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // voxel stream
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [VOXEL_BITS-1:0]    voxel_value,
  // gradient stream
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [GRAD_W-1:0] grad_x,
  output logic signed [GRAD_W-1:0] grad_y,
  output logic [CNT_W-1:0]         col_index,
  output logic [CNT_W-1:0]         row_index,
  output logic                     last_in_slice
);

  // line store addressing: counters are CNT_W wide, the stores MAX_WIDTH deep
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int XW     = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int WMAX   = (MAX_WIDTH < CNT_LIMIT) ? MAX_WIDTH : CNT_LIMIT;
  // difference width: wide enough for any voxel pair and for the clamp limit
  localparam int DIFF_W = (VOXEL_BITS + 2 > 10) ? VOXEL_BITS + 2 : 10;
  localparam int QCW    = $clog2(Q_DEPTH + 1);
  localparam int NCELLS = 2;

  localparam logic signed [DIFF_W-1:0] SAT_POS = DIFF_W'(GRAD_SAT);
  localparam logic signed [DIFF_W-1:0] SAT_NEG = -SAT_POS;

  function automatic logic signed [GRAD_W-1:0] clamp_grad(
    input logic signed [DIFF_W-1:0] d
  );
    logic signed [GRAD_W-1:0] res;
    priority if (d > SAT_POS) begin
      res = GRAD_W'(SAT_POS);
    end else if (d < SAT_NEG) begin
      res = GRAD_W'(SAT_NEG);
    end else begin
      res = d[GRAD_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] slice_width;
  logic [CFG_W-1:0] slice_height;
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_width  <= CFG_W'(SIZE_RESET);
      slice_height <= CFG_W'(SIZE_RESET);
    end else if (cfg_write) begin
      unique case (cdg_reg_t'(cfg_index))
        REG_SLICE_WIDTH:  slice_width  <= cfg_data;
        REG_SLICE_HEIGHT: slice_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes clamped into the range the counters and stores can handle
  always_comb begin
    priority if (slice_width < CFG_W'(MIN_SIZE)) begin
      w_eff = CFG_W'(MIN_SIZE);
    end else if (slice_width > CFG_W'(WMAX)) begin
      w_eff = CFG_W'(WMAX);
    end else begin
      w_eff = slice_width;
    end
    priority if (slice_height < CFG_W'(MIN_SIZE)) begin
      h_eff = CFG_W'(MIN_SIZE);
    end else if (slice_height > CFG_W'(CNT_LIMIT)) begin
      h_eff = CFG_W'(CNT_LIMIT);
    end else begin
      h_eff = slice_height;
    end
  end

  // ---------------------------------------------------------------- accept stage
  logic              accept;
  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  row;
  logic [CNT_W-1:0]  col_next;
  logic [CNT_W-1:0]  row_next;
  logic [CFG_W-1:0]  col_inc;
  logic [CFG_W-1:0]  row_inc;
  logic              hit;
  logic              last;
  logic [XW-1:0]     col_x;
  logic [XW-1:0]     col_next_x;

  assign accept = in_valid && !in_stall;

  always_comb begin
    col_inc  = {1'b0, col} + 1'b1;
    row_inc  = {1'b0, row} + 1'b1;
    col_next = col_inc[CNT_W-1:0];
    row_next = row;
    if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = (row_inc >= h_eff) ? '0 : row_inc[CNT_W-1:0];
    end
  end

  // result for the centre one row up; only interior centres count
  assign hit  = (row >= CNT_W'(2)) && ({1'b0, row} <= h_eff - 1'b1) &&
                (col != '0) && ({1'b0, col} <= w_eff - CFG_W'(2));
  assign last = ({1'b0, row} == h_eff - 1'b1) && ({1'b0, col} == w_eff - CFG_W'(2));

  assign col_x      = XW'(col);
  assign col_next_x = XW'(col_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // ---------------------------------------------------------------- s1 stage
  logic                  s1_valid;
  logic                  s1_hit;
  logic                  s1_last;
  logic                  s1_in_range;
  logic [AW-1:0]         s1_addr;
  logic [VOXEL_BITS-1:0] s1_voxel;
  logic [CNT_W-1:0]      s1_col;
  logic [CNT_W-1:0]      s1_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit      <= hit;
      s1_last     <= last;
      s1_in_range <= col_x < XW'(MAX_WIDTH);
      s1_addr     <= col_x[AW-1:0];
      s1_voxel    <= voxel_value;
      s1_col      <= col;
      s1_row      <= row - 1'b1;
    end
  end

  // older_line: row two up at this column, read at the item's own column.
  // newer_line: row one up, read one column ahead so the chain holds c+1, c, c-1.
  logic [VOXEL_BITS-1:0] older_rd;
  logic [VOXEL_BITS-1:0] newer_rd;
  logic [VOXEL_BITS-1:0] cell_q [NCELLS];

  cdg_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (VOXEL_BITS)
  ) u_older_line (
    .clk   (clk),
    .we    (s1_valid && s1_in_range),
    .waddr (s1_addr),
    .wdata (cell_q[0]),
    .re    (accept),
    .raddr (col_x[AW-1:0]),
    .rdata (older_rd)
  );

  cdg_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (VOXEL_BITS)
  ) u_newer_line (
    .clk   (clk),
    .we    (s1_valid && s1_in_range),
    .waddr (s1_addr),
    .wdata (s1_voxel),
    .re    (accept),
    .raddr (col_next_x[AW-1:0]),
    .rdata (newer_rd)
  );

  // chain of centre-row cells: cell 0 holds column c, cell 1 column c-1
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    cdg_cell #(
      .DATA_W (VOXEL_BITS)
    ) u_cell (
      .clk   (clk),
      .shift (s1_valid),
      .d     ((i == 0) ? newer_rd : cell_q[(i == 0) ? 0 : i - 1]),
      .q     (cell_q[i])
    );
  end

  cdg_result_t           s1_result;
  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;

  assign diff_x = $signed(DIFF_W'(newer_rd)) - $signed(DIFF_W'(cell_q[NCELLS-1]));
  assign diff_y = $signed(DIFF_W'(s1_voxel)) - $signed(DIFF_W'(older_rd));

  always_comb begin
    s1_result.grad_x        = clamp_grad(diff_x);
    s1_result.grad_y        = clamp_grad(diff_y);
    s1_result.col_index     = s1_col;
    s1_result.row_index     = s1_row;
    s1_result.last_in_slice = s1_last;
  end

  // ---------------------------------------------------------------- output
  logic               q_push;
  logic               q_pop;
  logic [QCW-1:0]     q_count;
  logic [QCW:0]       q_used;
  cdg_result_t        q_head;

  assign q_push = s1_valid && s1_hit;
  assign q_pop  = out_valid && !out_stall;

  cdg_out_queue #(
    .DEPTH (Q_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (s1_result),
    .pop       (q_pop),
    .not_empty (out_valid),
    .head      (q_head),
    .count     (q_count)
  );

  // room for the queued results plus the item now in s1 plus one more
  assign q_used   = {1'b0, q_count} + {{QCW{1'b0}}, s1_valid};
  assign in_stall = q_used >= (QCW + 1)'(Q_DEPTH);

  assign grad_x        = q_head.grad_x;
  assign grad_y        = q_head.grad_y;
  assign col_index     = q_head.col_index;
  assign row_index     = q_head.row_index;
  assign last_in_slice = q_head.last_in_slice;

  // ---------------------------------------------------------------- checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < QCW'(Q_DEPTH)))
    else $error("result pushed into a full queue");

  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (col_index != '0) && (row_index != '0))
    else $error("border voxel reported as a result");

  a_stall_clear: assert property (@(posedge clk) disable iff (rst)
    (q_count == '0) && !s1_valid |-> !in_stall)
    else $error("input stalled with nothing in flight");

endmodule

// ===== sv/cdg_line_store.sv =====
// One line store: single write port, one read port with registered read data.
module cdg_line_store
  import cdg_pkg::*;
#(
  parameter int DEPTH  = MAX_WIDTH_DEF,
  parameter int DATA_W = VOXEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/cdg_cell.sv =====
// Window cell: holds one voxel of the centre row and passes it on along the chain.
module cdg_cell
  import cdg_pkg::*;
#(
  parameter int DATA_W = VOXEL_BITS_DEF
) (
  input  logic              clk,
  input  logic              shift,
  input  logic [DATA_W-1:0] d,
  output logic [DATA_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== sv/cdg_out_queue.sv =====
// Small result queue in front of the output channel.
module cdg_out_queue
  import cdg_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  cdg_result_t                push_data,
  input  logic                       pop,
  output logic                       not_empty,
  output cdg_result_t                head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cdg_result_t      entry [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW-1:0]    wr_ptr_next;
  logic [PW-1:0]    rd_ptr_next;
  logic [CW-1:0]    count_next;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    priority if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  assign not_empty = (count != '0);
  assign head      = entry[rd_ptr];

endmodule
